/* hdl/scaled_oneshot_timer_bank_top_defines.svh */
// assertion macros for the scaled one-shot timer bank
`ifndef SCALED_ONESHOT_TIMER_BANK_TOP_DEFINES_SVH
`define SCALED_ONESHOT_TIMER_BANK_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define SOTB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication from a trigger to a consequence in the next cycle
`define SOTB_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);
`else
`define SOTB_ASSERT(label, clk, rst_n, prop, msg)
`define SOTB_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg)
`endif

`endif

/* hdl/sotb_pkg.sv */
// shared types and constants of the scaled one-shot timer bank
`timescale 1ns / 1ps

package sotb_pkg;

    // default bank depth
    localparam int MAX_TIMERS_DEF = 16;

    // field widths
    localparam int TS_W    = 32;
    localparam int DUR_W   = 24;
    localparam int TAG_W   = 8;
    localparam int REM_W   = 34;
    localparam int SCALE_W = 16;
    localparam int FRAC_W  = 8;
    localparam int DELTA_W = 48;
    localparam int GAME_W  = 56;
    localparam int GOUT_W  = 48;

    // reset value of the time scale register (1.0)
    localparam logic [SCALE_W-1:0] TIME_SCALE_RST = 16'd256;

    // item kinds
    localparam logic FUNC_TICK   = 1'b0;
    localparam logic FUNC_CREATE = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_EXPIRED   = 2'd0;
    localparam logic [1:0] KIND_TICK_DONE = 2'd1;
    localparam logic [1:0] KIND_CREATED   = 2'd2;
    localparam logic [1:0] KIND_REFUSED   = 2'd3;

    typedef struct packed {
        logic              func;
        logic [TS_W-1:0]   timestamp_ms;
        logic [DUR_W-1:0]  duration_ms;
        logic              unscaled;
        logic [TAG_W-1:0]  timer_tag;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        kind;
        logic [TAG_W-1:0]  tag;
        logic [GOUT_W-1:0] game_time_ms;
        logic              last;
    } t_out_item;

    // one timer as held in a cell
    typedef struct packed {
        logic [REM_W-1:0] remaining;
        logic             unscaled;
        logic [TAG_W-1:0] tag;
    } t_timer;

    // per-cell control
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

/* hdl/scaled_oneshot_timer_bank_top.sv */
// top level of the scaled one-shot timer bank
`timescale 1ns / 1ps
`include "scaled_oneshot_timer_bank_top_defines.svh"

// A create item gives one result (created or refused) in the next cycle;
// busy stays low, so creates may come every cycle. A tick item holds busy
// high through the DELTA state, one STEP state per active timer and the DONE
// state: the raw delta is taken at the accepting edge, the DELTA state forms
// the scaled product, then the chain of timer cells shifts once per active
// timer through the single head unit, which strobes an expiry result in the
// cycle after each expired timer's step, in creation order, and the DONE state
// forms the game-time result (last set), which shows in the first cycle after busy
// falls. Results are strobed for one cycle on o_res_vld and cannot be held
// off. Write the time scale only while busy is low and no result is still
// to come.
module scaled_oneshot_timer_bank_top
    import sotb_pkg::*;
#(
    parameter int MAX_TIMERS = MAX_TIMERS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  t_in_item            i_item,
    input  logic                i_cfg_we,
    input  logic [SCALE_W-1:0]  i_cfg_wdata,
    output logic                o_res_vld,
    output t_out_item           o_res
);

    localparam int CNT_W = $clog2(MAX_TIMERS + 1);

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DELTA = 2'd1;
    localparam logic [1:0] ST_STEP  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [SCALE_W-1:0] r_scale;
    logic [TS_W-1:0]    r_prev_ts, n_prev_ts;
    logic [TS_W-1:0]    r_raw, n_raw;
    logic [DELTA_W-1:0] r_scaled, n_scaled;
    logic [GAME_W-1:0]  r_game, n_game;
    logic [CNT_W-1:0]   r_len, n_len;
    logic [CNT_W-1:0]   r_steps, n_steps;
    t_out_item          r_res, n_res;
    logic               r_res_vld, n_res_vld;

    logic               w_accept;
    logic               w_create;
    logic               w_full;
    logic               w_expired;
    t_timer             w_new;
    t_timer             w_next;
    t_timer             w_load;
    logic [GAME_W-1:0]  w_game_sum;
    t_timer             w_cell [MAX_TIMERS];

    assign w_accept   = start && !busy;
    assign w_create   = w_accept && (i_item.func == FUNC_CREATE);
    assign w_full     = (r_len == CNT_W'(MAX_TIMERS));
    assign w_game_sum = r_game + GAME_W'(r_scaled);

    // timer formed from a create item
    always_comb begin
        w_new.remaining = REM_W'({i_item.duration_ms, {FRAC_W{1'b0}}});
        w_new.unscaled  = i_item.unscaled;
        w_new.tag       = i_item.timer_tag;
    end

    // head unit on cell zero
    sotb_head u_head (
        .i_head    (w_cell[0]),
        .i_raw     (r_raw),
        .i_scaled  (r_scaled),
        .o_expired (w_expired),
        .o_next    (w_next)
    );

    assign w_load = (r_state == ST_STEP) ? w_next : w_new;

    // chain of timer cells, shifting toward the head while stepping
    for (genvar gi = 0; gi < MAX_TIMERS; gi++) begin : g_cell
        t_cell_ctl w_ctl;
        t_timer    w_nbr;

        always_comb begin
            w_ctl.shift = (r_state == ST_STEP);
            w_ctl.load  = ((r_state == ST_STEP) && !w_expired
                           && (r_len == CNT_W'(gi + 1)))
                       || (w_create && (r_len == CNT_W'(gi)));
        end

        if (gi == MAX_TIMERS - 1) begin : g_tail
            assign w_nbr = '0;
        end else begin : g_mid
            assign w_nbr = w_cell[gi+1];
        end

        sotb_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_nbr  (w_nbr),
            .i_load (w_load),
            .o_cell (w_cell[gi])
        );
    end

    // sequencer and result formation
    always_comb begin
        n_state   = r_state;
        n_prev_ts = r_prev_ts;
        n_raw     = r_raw;
        n_scaled  = r_scaled;
        n_game    = r_game;
        n_len     = r_len;
        n_steps   = r_steps;
        n_res     = r_res;
        n_res_vld = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_item.func == FUNC_CREATE) begin
                        n_res_vld = 1'b1;
                        n_res.game_time_ms = '0;
                        n_res.last = 1'b1;
                        if (w_full) begin
                            n_res.kind = KIND_REFUSED;
                            n_res.tag  = '0;
                        end else begin
                            n_res.kind = KIND_CREATED;
                            n_res.tag  = i_item.timer_tag;
                            n_len      = r_len + CNT_W'(1);
                        end
                    end else begin
                        n_raw     = i_item.timestamp_ms - r_prev_ts;
                        n_prev_ts = i_item.timestamp_ms;
                        n_state   = ST_DELTA;
                    end
                end
            end
            ST_DELTA: begin
                n_scaled = DELTA_W'(r_raw) * DELTA_W'(r_scale);
                n_steps  = r_len;
                n_state  = (r_len == '0) ? ST_DONE : ST_STEP;
            end
            ST_STEP: begin
                n_steps = r_steps - CNT_W'(1);
                if (w_expired) begin
                    n_len     = r_len - CNT_W'(1);
                    n_res_vld = 1'b1;
                    n_res.kind = KIND_EXPIRED;
                    n_res.tag  = w_cell[0].tag;
                    n_res.game_time_ms = '0;
                    n_res.last = 1'b0;
                end
                if (r_steps == CNT_W'(1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_game    = w_game_sum;
                n_res_vld = 1'b1;
                n_res.kind = KIND_TICK_DONE;
                n_res.tag  = '0;
                n_res.game_time_ms = w_game_sum[GAME_W-1:FRAC_W];
                n_res.last = 1'b1;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_scale   <= TIME_SCALE_RST;
            r_prev_ts <= '0;
            r_game    <= '0;
            r_len     <= '0;
            r_steps   <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_prev_ts <= n_prev_ts;
            r_game    <= n_game;
            r_len     <= n_len;
            r_steps   <= n_steps;
            r_res_vld <= n_res_vld;
            if (i_cfg_we) begin
                r_scale <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_raw    <= n_raw;
        r_scaled <= n_scaled;
        r_res    <= n_res;
    end

    assign busy      = (r_state != ST_IDLE);
    assign o_res_vld = r_res_vld;
    assign o_res     = r_res;

    // checks
    `SOTB_ASSERT(a_len_bound, i_clk, i_rst_n, r_len <= CNT_W'(MAX_TIMERS),
                 "timer count over bank size")
    `SOTB_ASSERT(a_steps_idle, i_clk, i_rst_n, (r_state != ST_IDLE) || (r_steps == '0),
                 "step count left over in idle")
    `SOTB_ASSERT(a_expiry_not_last, i_clk, i_rst_n,
                 !(o_res_vld && o_res.kind == KIND_EXPIRED) || !o_res.last,
                 "expiry item marked last")
    `SOTB_ASSERT_NEXT(a_create_result, i_clk, i_rst_n, w_create,
                      o_res_vld && o_res.last
                      && (o_res.kind == KIND_CREATED || o_res.kind == KIND_REFUSED),
                      "create item without its result")

endmodule

/* hdl/sotb_cell.sv */
// one timer cell of the chain: loads a new value or takes its neighbor's
`timescale 1ns / 1ps

module sotb_cell
    import sotb_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_timer    i_nbr,
    input  t_timer    i_load,
    output t_timer    o_cell
);

    t_timer r_timer;

    // load wins over the shift toward the head
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_timer <= i_load;
        end else if (i_ctl.shift) begin
            r_timer <= i_nbr;
        end
    end

    assign o_cell = r_timer;

endmodule

/* hdl/sotb_head.sv */
// head unit: checks the timer at the head of the chain against its delta
`timescale 1ns / 1ps

module sotb_head
    import sotb_pkg::*;
(
    input  t_timer             i_head,
    input  logic [TS_W-1:0]    i_raw,
    input  logic [DELTA_W-1:0] i_scaled,
    output logic               o_expired,
    output t_timer             o_next
);

    logic [DELTA_W-1:0] w_real;
    logic [DELTA_W-1:0] w_delta;
    logic [DELTA_W-1:0] w_rem;
    logic [DELTA_W-1:0] w_diff;

    // pick the real or the scaled delta
    assign w_real  = DELTA_W'({i_raw, {FRAC_W{1'b0}}});
    assign w_delta = i_head.unscaled ? w_real : i_scaled;
    assign w_rem   = DELTA_W'(i_head.remaining);

    // expire at or below zero, else subtract exactly
    assign o_expired = (w_delta >= w_rem);
    assign w_diff    = w_rem - w_delta;

    always_comb begin
        o_next           = i_head;
        o_next.remaining = w_diff[REM_W-1:0];
    end

endmodule

/* bench/scaled_oneshot_timer_bank_checker.sv */
// checker for the scaled one-shot timer bank: predicts results and compares them
`timescale 1ns / 1ps

module scaled_oneshot_timer_bank_checker
    import sotb_pkg::*;
#(
    parameter int MAX_TIMERS = MAX_TIMERS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  t_in_item           i_item,
    input  logic               i_cfg_we,
    input  logic [SCALE_W-1:0] i_cfg_wdata,
    input  logic               i_res_vld,
    input  t_out_item          i_res,
    output int                 o_fail_count,
    output int                 o_pending
);

    // predicted bank contents, in creation order
    logic [REM_W-1:0]   timer_left [MAX_TIMERS];
    logic               timer_real [MAX_TIMERS];
    logic [TAG_W-1:0]   timer_tag  [MAX_TIMERS];
    int unsigned        live_timers;
    logic [TS_W-1:0]    last_stamp;
    logic [GAME_W-1:0]  game_clock;
    logic [SCALE_W-1:0] scale_factor;

    // results still owed by the block, oldest first
    t_out_item due_results[$];
    int        fail_count;

    // append one expected result behind the others
    function automatic void owe_result(t_out_item r);
        due_results = {due_results, r};
    endfunction

    // advance the predicted bank by one item and queue what it must report
    function automatic void apply_timer_item(t_in_item it);
        t_out_item          r;
        logic [TS_W-1:0]    raw;
        logic [DELTA_W-1:0] real_delta;
        logic [DELTA_W-1:0] game_delta;
        logic [DELTA_W-1:0] d;
        int unsigned        keep;
        r = '0;
        if (it.func == FUNC_CREATE) begin
            if (live_timers >= MAX_TIMERS) begin
                r.kind = KIND_REFUSED;
            end else begin
                timer_left[live_timers] = REM_W'({it.duration_ms, {FRAC_W{1'b0}}});
                timer_real[live_timers] = it.unscaled;
                timer_tag[live_timers]  = it.timer_tag;
                live_timers++;
                r.kind = KIND_CREATED;
                r.tag  = it.timer_tag;
            end
            r.last = 1'b1;
            owe_result(r);
        end else begin
            raw        = it.timestamp_ms - last_stamp;
            real_delta = DELTA_W'(raw) << FRAC_W;
            game_delta = DELTA_W'(raw) * DELTA_W'(scale_factor);
            last_stamp = it.timestamp_ms;
            keep       = 0;
            // expire in creation order, compact the survivors
            for (int unsigned i = 0; i < live_timers; i++) begin
                d = timer_real[i] ? real_delta : game_delta;
                if (d >= DELTA_W'(timer_left[i])) begin
                    r      = '0;
                    r.kind = KIND_EXPIRED;
                    r.tag  = timer_tag[i];
                    owe_result(r);
                end else begin
                    timer_left[keep] = timer_left[i] - REM_W'(d);
                    timer_real[keep] = timer_real[i];
                    timer_tag[keep]  = timer_tag[i];
                    keep++;
                end
            end
            live_timers    = keep;
            game_clock     = game_clock + GAME_W'(game_delta);
            r              = '0;
            r.kind         = KIND_TICK_DONE;
            r.game_time_ms = game_clock[FRAC_W +: GOUT_W];
            r.last         = 1'b1;
            owe_result(r);
        end
    endfunction

    function automatic void report_bad(string what, t_out_item want, t_out_item got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t: %s: expected kind=%0d tag=%02h game=%012h last=%0b,",
                     $realtime, what, want.kind, want.tag, want.game_time_ms, want.last);
            $display("    got kind=%0d tag=%02h game=%012h last=%0b",
                     got.kind, got.tag, got.game_time_ms, got.last);
        end
    endfunction

    // compare one strobed result against the oldest expectation
    function automatic void check_result(t_out_item got);
        t_out_item want;
        if (due_results.size() == 0) begin
            report_bad("result with nothing expected", '0, got);
        end else begin
            want = due_results.pop_front();
            if (got.kind !== want.kind || got.tag !== want.tag ||
                got.game_time_ms !== want.game_time_ms || got.last !== want.last) begin
                report_bad("result mismatch", want, got);
            end
        end
    endfunction

    // results first: none of them can belong to an item taken at the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            live_timers  = 0;
            last_stamp   = '0;
            game_clock   = '0;
            scale_factor = TIME_SCALE_RST;
            due_results.delete();
        end else begin
            if (i_res_vld) begin
                check_result(i_res);
            end
            if (i_cfg_we) begin
                scale_factor = i_cfg_wdata;
            end
            if (i_start && !i_busy) begin
                apply_timer_item(i_item);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= due_results.size();
    end

endmodule

/* bench/tb_scaled_oneshot_timer_bank_top.sv */
// testbench top for the scaled one-shot timer bank: stimulus and verdict
`timescale 1ns / 1ps

module tb_scaled_oneshot_timer_bank_top;
    import sotb_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    t_in_item           item;
    logic               cfg_we;
    logic [SCALE_W-1:0] cfg_wdata;
    logic               res_vld;
    t_out_item          res;
    int                 fail_count;
    int                 pending;

    // running timestamp for ticks
    logic [TS_W-1:0]    now_ms;
    logic               no_gaps;

    scaled_oneshot_timer_bank_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (item),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_res_vld   (res_vld),
        .o_res       (res)
    );

    scaled_oneshot_timer_bank_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (item),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_res_vld    (res_vld),
        .i_res        (res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 20 ns clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hang guard
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic t_in_item noise_item();
        t_in_item it;
        it.func         = 1'($urandom);
        it.timestamp_ms = $urandom;
        it.duration_ms  = 24'($urandom);
        it.unscaled     = 1'($urandom);
        it.timer_tag    = 8'($urandom);
        return it;
    endfunction

    function automatic t_in_item tick_at(logic [TS_W-1:0] ts);
        t_in_item it;
        it              = noise_item();
        it.func         = FUNC_TICK;
        it.timestamp_ms = ts;
        return it;
    endfunction

    function automatic t_in_item create_timer(logic [DUR_W-1:0] dur, logic uns,
                                              logic [TAG_W-1:0] tg);
        t_in_item it;
        it             = noise_item();
        it.func        = FUNC_CREATE;
        it.duration_ms = dur;
        it.unscaled    = uns;
        it.timer_tag   = tg;
        return it;
    endfunction

    // hold the item on the port until the block takes it
    task automatic drive_item(t_in_item it);
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy);
    endtask

    // random gap with junk on the item port
    task automatic idle_gap();
        int n;
        n = $urandom_range(1, 8);
        repeat (n) begin
            start <= 1'b0;
            item  <= noise_item();
            @(posedge clk);
        end
    endtask

    // wait until every expected result has come and the block is idle
    task automatic drain_bank();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_time_scale(logic [SCALE_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly short durations and small steps so that timers really expire
    function automatic t_in_item random_timer_item();
        int r;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 1) == 1) begin
            if (r < 10) begin
                return create_timer('0, 1'($urandom), 8'($urandom));
            end else if (r < 80) begin
                return create_timer(24'($urandom_range(1, 3000)), 1'($urandom),
                                    8'($urandom));
            end
            return create_timer(24'($urandom), 1'($urandom), 8'($urandom));
        end
        if (r < 80) begin
            now_ms = now_ms + TS_W'($urandom_range(0, 600));
        end else if (r >= 90) begin
            now_ms = $urandom;
        end
        return tick_at(now_ms);
    endfunction

    task automatic random_phase(int count);
        for (int k = 0; k < count; k++) begin
            if (!no_gaps && $urandom_range(0, 99) < 30) begin
                idle_gap();
            end
            if ($urandom_range(0, 99) < 2) begin
                drain_bank();
            end
            drive_item(random_timer_item());
        end
    endtask

    logic [SCALE_W-1:0] phase_scale [6];

    initial begin
        rst_n     <= 1'b0;
        start     <= 1'b0;
        item      <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        no_gaps   = 1'b0;
        now_ms    = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first tick counts from timestamp zero
        drive_item(tick_at(32'd1000));
        // zero duration expires even with zero delta
        drive_item(create_timer('0, 1'b0, 8'hA5));
        drive_item(tick_at(32'd1000));
        // fill the bank, then one refused create
        for (int i = 0; i < MAX_TIMERS_DEF; i++) begin
            drive_item(create_timer((i == 0) ? 24'hFFFFFF :
                                    (i == 1) ? 24'd0 :
                                    (i == 2) ? 24'd1 : 24'(100 * i),
                                    i[0],
                                    (i == 3) ? 8'h00 : (i == 4) ? 8'hFF : 8'(8'h10 + i)));
        end
        drive_item(create_timer(24'd5, 1'b1, 8'h77));
        drive_item(tick_at(32'd1200));
        drive_item(tick_at(32'hFFFFFFFF));
        // timestamp wrapping past zero
        drive_item(create_timer(24'd50, 1'b1, 8'h3C));
        drive_item(tick_at(32'h00000000));
        now_ms = '0;

        // random phases under several time scales
        random_phase(66);
        phase_scale[0] = 16'd0;
        phase_scale[1] = 16'hFFFF;
        phase_scale[2] = 16'd128;
        phase_scale[3] = 16'($urandom);
        phase_scale[4] = 16'd1;
        phase_scale[5] = TIME_SCALE_RST;
        for (int p = 0; p < 6; p++) begin
            drain_bank();
            write_time_scale(phase_scale[p]);
            no_gaps = (p == 2);
            random_phase(66);
        end

        drain_bank();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
